// ===== src/morse_code_keyer_assert.svh =====
// Assertion macros used by the keyer top level.
`ifndef MORSE_CODE_KEYER_ASSERT_SVH
`define MORSE_CODE_KEYER_ASSERT_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define MCK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define MCK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mck_pkg.sv =====
// Shared types, constants and code tables for the Morse keyer.
`timescale 1ns / 1ps
package mck_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [2:0] DOT_UNITS        = 3'd1;
    localparam logic [2:0] DASH_UNITS       = 3'd3;
    localparam logic [2:0] SYMBOL_GAP_UNITS = 3'd1;
    localparam logic [2:0] LETTER_GAP_UNITS = 3'd2;
    localparam logic [2:0] WORD_GAP_UNITS   = 3'd7;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Packed as (symbol count << 5) | pattern, first symbol in the highest used bit.
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h41, 8'h88, 8'h8A, 8'h64, 8'h20, 8'h82, 8'h66, 8'h80,
        8'h40, 8'h87, 8'h65, 8'h84, 8'h43, 8'h42, 8'h67, 8'h86,
        8'h8D, 8'h62, 8'h60, 8'h21, 8'h61, 8'h81, 8'h63, 8'h89,
        8'h8B, 8'h8C
    };

    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8,
        8'hBC, 8'hBE
    };

    // Classified character: dashes[i] is symbol i in send order.
    typedef struct packed {
        logic       is_space;
        logic [2:0] count;
        logic [4:0] dashes;
    } morse_entry_t;

    // Returns the packed code, zero for bytes without a Morse code.
    function automatic logic [7:0] code_lookup(input logic [7:0] ch);
        logic [7:0] off;
        logic [7:0] code;
        code = 8'h00;
        off  = 8'h00;
        if (ch inside {[8'h41:8'h5A]}) begin
            off  = ch - 8'h41;
            code = LETTER_CODES[off[4:0]];
        end
        else if (ch inside {[8'h61:8'h7A]}) begin
            off  = ch - 8'h61;
            code = LETTER_CODES[off[4:0]];
        end
        else if (ch inside {[8'h30:8'h39]}) begin
            off  = ch - 8'h30;
            code = DIGIT_CODES[off[3:0]];
        end
        return code;
    endfunction

endpackage

// ===== src/mck_char_if.sv =====
// Character request channel: valid, ready and one ASCII byte.
`timescale 1ns / 1ps
interface mck_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

// ===== src/mck_seg_if.sv =====
// Keying segment channel: valid, ready and one segment.
`timescale 1ns / 1ps
interface mck_seg_if;
    logic       valid;
    logic       ready;
    logic       tone_on;
    logic [2:0] duration_units;
    logic       last_of_run;

    modport source (output valid, output tone_on, output duration_units,
                    output last_of_run, input ready);
    modport sink   (input valid, input tone_on, input duration_units,
                    input last_of_run, output ready);
endinterface

// ===== src/morse_code_keyer.sv =====
// Top level of the Morse keyer: classifier, entry queue and segment sequencer.
`timescale 1ns / 1ps
// Takes one ASCII byte per request on chars and gives its keying segments on
// segments, one per cycle while the sink keeps ready high. A letter or digit of
// n symbols gives 2n+1 segments (tone, 1-unit gap per symbol, then a 2-unit
// letter gap marked last_of_run); a space gives one 7-unit silent segment and
// any other byte one 2-unit silent segment. Lowercase keys as uppercase. The
// segment sequencer issues one segment per cycle while ready is high, so a
// character holds it for all its segments (1 to 11), setting the sustained rate;
// the classifier keeps taking characters into a QUEUE_DEPTH-entry queue meanwhile.
// With the queue empty, a taken character passes a queue slot and entry_reg
// into the output register. Reset clears control state only; no clearing pass is needed.
module morse_code_keyer #(
    parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    mck_char_if.sink   chars,
    mck_seg_if.source  segments
);
    import mck_pkg::*;

    `include "morse_code_keyer_assert.svh"

    logic         push_valid, push_ready;
    morse_entry_t push_data;
    logic         pop_valid, pop_ready;
    morse_entry_t pop_data;

    // Classify each request as space, coded character or unmapped byte.
    mck_front u_front (
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouples character intake from segment delivery.
    mck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Walks each entry's segments; next entry loads as the last one issues.
    mck_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .segments  (segments)
    );

    // A tone is always followed by its gap, so it never ends a run.
    `MCK_ASSERT_SAME(a_tone_not_last, segments.valid && segments.tone_on,
        !segments.last_of_run, "tone segment marked last")

    // Word and letter gaps only ever close a run.
    `MCK_ASSERT_SAME(a_long_gap_is_last,
        segments.valid && !segments.tone_on &&
        (segments.duration_units == WORD_GAP_UNITS ||
         segments.duration_units == LETTER_GAP_UNITS),
        segments.last_of_run, "closing gap not marked last")

    // Mid-run, the sequencer has the next segment ready straight away.
    `MCK_ASSERT_NEXT(a_run_no_bubble,
        segments.valid && segments.ready && !segments.last_of_run,
        segments.valid, "bubble inside a run")

    // Only valid durations leave the block.
    `MCK_ASSERT_SAME(a_units_legal, segments.valid,
        segments.duration_units != 3'd0, "zero-length segment")

endmodule

// ===== src/mck_front.sv =====
// Front end: takes characters and classifies them into queue entries.
`timescale 1ns / 1ps
module mck_front (
    mck_char_if.sink            chars,
    output logic                push_valid,
    input  logic                push_ready,
    output mck_pkg::morse_entry_t push_data
);
    import mck_pkg::*;

    logic [7:0] code;
    logic [2:0] count;
    logic [4:0] pattern;
    logic [2:0] src_idx;
    logic [4:0] dashes;

    assign code    = code_lookup(chars.character);
    assign count   = code[7:5];
    assign pattern = code[4:0];

    // Reorder so the first symbol sent sits in bit 0.
    always_comb
    begin
        dashes  = 5'b0;
        src_idx = 3'd0;
        for (int i = 0; i < 5; i++)
        begin
            src_idx = count - 3'(i + 1);
            if (3'(i) < count)
            begin
                dashes[i] = pattern[src_idx];
            end
        end
    end

    assign push_data.is_space = (chars.character == SPACE_CHAR);
    assign push_data.count    = count;
    assign push_data.dashes   = dashes;

    assign push_valid  = chars.valid;
    assign chars.ready = push_ready;

endmodule

// ===== src/mck_queue.sv =====
// Short FIFO between the classifier and the segment sequencer.
`timescale 1ns / 1ps
module mck_queue #(
    parameter int DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  mck_pkg::morse_entry_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output mck_pkg::morse_entry_t pop_data
);
    import mck_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    morse_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != FULL_CNT);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/mck_back.sv =====
// Back end: steps through one entry's segments into the output register.
`timescale 1ns / 1ps
module mck_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  mck_pkg::morse_entry_t pop_data,
    mck_seg_if.source             segments
);
    import mck_pkg::*;

    morse_entry_t entry_reg;
    logic         busy_reg, busy_next;
    logic [3:0]   seg_idx_reg, seg_idx_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_tone_reg;
    logic [2:0]   out_units_reg;
    logic         out_last_reg;

    logic         advance, do_pop;
    logic         seg_last, seg_tone;
    logic [2:0]   seg_units;
    logic [2:0]   sym_idx;
    logic [7:0]   dash_pad;

    // Even index: symbol tone; odd: inter-symbol gap; index 2*count: letter gap.
    assign sym_idx  = seg_idx_reg[3:1];
    assign dash_pad = {3'b000, entry_reg.dashes};
    assign seg_last = entry_reg.is_space || (seg_idx_reg == {entry_reg.count, 1'b0});
    assign seg_tone = !seg_last && !seg_idx_reg[0];

    always_comb
    begin
        if (entry_reg.is_space)
        begin
            seg_units = WORD_GAP_UNITS;
        end
        else if (seg_last)
        begin
            seg_units = LETTER_GAP_UNITS;
        end
        else if (seg_idx_reg[0])
        begin
            seg_units = SYMBOL_GAP_UNITS;
        end
        else
        begin
            seg_units = dash_pad[sym_idx] ? DASH_UNITS : DOT_UNITS;
        end
    end

    assign advance   = busy_reg && (!out_valid_reg || segments.ready);
    assign pop_ready = !busy_reg || (advance && seg_last);
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        busy_next    = busy_reg;
        seg_idx_next = seg_idx_reg;
        if (do_pop)
        begin
            busy_next    = 1'b1;
            seg_idx_next = 4'd0;
        end
        else if (advance)
        begin
            seg_idx_next = seg_idx_reg + 4'd1;
            if (seg_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (segments.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seg_idx_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seg_idx_reg   <= seg_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            entry_reg <= pop_data;
        end
        if (advance)
        begin
            out_tone_reg  <= seg_tone;
            out_units_reg <= seg_units;
            out_last_reg  <= seg_last;
        end
    end

    assign segments.valid          = out_valid_reg;
    assign segments.tone_on        = out_tone_reg;
    assign segments.duration_units = out_units_reg;
    assign segments.last_of_run    = out_last_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Morse keyer: character requests in, keying segments out.
`timescale 1ns / 1ps
module tb;

    // Segment lengths in Morse units
    localparam logic [2:0] DOT_LEN        = 3'd1;
    localparam logic [2:0] DASH_LEN       = 3'd3;
    localparam logic [2:0] MARK_GAP_LEN   = 3'd1;
    localparam logic [2:0] CHAR_GAP_LEN   = 3'd2;
    localparam logic [2:0] WORD_GAP_LEN   = 3'd7;
    localparam logic [7:0] SPACE_BYTE     = 8'h20;

    localparam int RANDOM_CHARS   = 200;
    localparam int IDLE_PERCENT   = 14;
    localparam int STALL_LIMIT    = 1000; // cycles with no request taken on either side
    localparam int DRAIN_CYCLES   = 16;   // covers the queue, entry and output registers plus queue slack
    localparam int REPORT_LIMIT   = 10;

    // Opening set: table ends, both cases, all-dot and all-dash digits,
    // space, and bytes just outside each mapped range.
    localparam int OPENING_COUNT = 22;
    localparam logic [7:0] OPENING_CHARS [OPENING_COUNT] = '{
        8'h41, 8'h5A, 8'h61, 8'h7A,   // A Z a z
        8'h30, 8'h39, 8'h35,          // 0 9 5
        8'h45, 8'h54, 8'h51, 8'h59,   // E T Q Y
        8'h20,                        // space
        8'h00, 8'hFF, 8'h80, 8'h7F,   // NUL, top bytes, DEL
        8'h40, 8'h5B, 8'h60, 8'h7B,   // neighbours of the letter ranges
        8'h2F, 8'h3A                  // neighbours of the digit range
    };

    typedef struct packed {
        logic       tone_on;
        logic [2:0] duration_units;
        logic       last_of_run;
    } keying_seg_t;

    logic clk;
    logic rst_n;

    mck_char_if chars_if ();
    mck_seg_if  segs_if ();

    morse_code_keyer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars_if),
        .segments (segs_if)
    );

    logic [7:0]  chars_to_send [$];  // characters not yet offered
    keying_seg_t segs_expected [$];  // segments predicted, oldest first

    int chars_taken  = 0;
    int segs_seen    = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;
    int letters_sent = 0;
    int digits_sent  = 0;
    int spaces_sent  = 0;
    int others_sent  = 0;

    // Dot/dash string for a byte; empty for bytes with no Morse code.
    function automatic string morse_marks(input logic [7:0] ch);
        logic [7:0] up;
        up = ch;
        if (ch >= 8'h61 && ch <= 8'h7A)
            up = ch - 8'h20;
        case (up)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    // Number of dots and dashes for a byte.
    function automatic int mark_count(input logic [7:0] ch);
        string marks;
        marks = morse_marks(ch);
        return marks.len();
    endfunction

    // Appends the segment run that one accepted character should produce.
    function automatic void predict_keying(input logic [7:0] ch);
        string       marks;
        keying_seg_t seg;
        int          i;
        if (ch == SPACE_BYTE) begin
            // word gap replaces the letter gap entirely
            seg = '{1'b0, WORD_GAP_LEN, 1'b1};
            segs_expected.push_back(seg);
            return;
        end
        marks = morse_marks(ch);
        for (i = 0; i < marks.len(); i++) begin
            seg = '{1'b1, (marks[i] == "-") ? DASH_LEN : DOT_LEN, 1'b0};
            segs_expected.push_back(seg);
            seg = '{1'b0, MARK_GAP_LEN, 1'b0};
            segs_expected.push_back(seg);
        end
        seg = '{1'b0, CHAR_GAP_LEN, 1'b1};
        segs_expected.push_back(seg);
    endfunction

    // Mostly keyable characters, with a share of spaces and arbitrary bytes.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'h41 + 8'($urandom_range(25));
        else if (r < 50)
            return 8'h61 + 8'($urandom_range(25));
        else if (r < 70)
            return 8'h30 + 8'($urandom_range(9));
        else if (r < 78)
            return SPACE_BYTE;
        return 8'($urandom_range(255));
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Driver: offers the next queued character when the request slot is free, idling at random.
    // A window mid-run (characters 120 to 169) keeps valid up back to back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid <= 1'b0;
            chars_if.character <= 8'h00;
        end
        else if (!chars_if.valid || chars_if.ready)
        begin
            if (chars_if.valid)
            begin
                predict_keying(chars_if.character);
                chars_taken <= chars_taken + 1;
                if (chars_if.character == SPACE_BYTE)
                    spaces_sent <= spaces_sent + 1;
                else if (mark_count(chars_if.character) == 5)
                    digits_sent <= digits_sent + 1;
                else if (mark_count(chars_if.character) > 0)
                    letters_sent <= letters_sent + 1;
                else
                    others_sent <= others_sent + 1;
            end
            if (chars_to_send.size() > 0 &&
                ((chars_taken >= 120 && chars_taken < 170) ||
                 $urandom_range(99) >= IDLE_PERCENT))
            begin
                chars_if.valid <= 1'b1;
                chars_if.character <= chars_to_send.pop_front();
            end
            else
                chars_if.valid <= 1'b0;
        end
    end

    // Monitor: checks each taken segment against the oldest prediction and
    // throttles ready, except in a back-pressure-free window.
    always @(posedge clk or negedge rst_n)
    begin
        keying_seg_t want;
        if (!rst_n)
            segs_if.ready <= 1'b0;
        else
        begin
            if (segs_if.valid && segs_if.ready)
            begin
                segs_seen <= segs_seen + 1;
                if (segs_expected.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < REPORT_LIMIT)
                        $display("[%0t] segment with nothing pending: tone=%0b units=%0d last=%0b",
                                 $realtime, segs_if.tone_on, segs_if.duration_units,
                                 segs_if.last_of_run);
                end
                else
                begin
                    want = segs_expected.pop_front();
                    if (segs_if.tone_on !== want.tone_on ||
                        segs_if.duration_units !== want.duration_units ||
                        segs_if.last_of_run !== want.last_of_run)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $write("[%0t] segment %0d: expected tone=%0b units=%0d last=%0b,",
                                   $realtime, segs_seen, want.tone_on,
                                   want.duration_units, want.last_of_run);
                            $display(" got tone=%0b units=%0d last=%0b",
                                     segs_if.tone_on, segs_if.duration_units,
                                     segs_if.last_of_run);
                        end
                    end
                end
            end
            segs_if.ready <= (segs_seen >= 400 && segs_seen < 650) ||
                             ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: a run of cycles with no request taken on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chars_if.valid && chars_if.ready) || (segs_if.valid && segs_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timed out after %0d cycles with no progress", idle_cycles);
                $display("FAIL morse_code_keyer");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int n;
        rst_n = 1'b0;

        for (n = 0; n < OPENING_COUNT; n++)
            chars_to_send.push_back(OPENING_CHARS[n]);
        for (n = 0; n < RANDOM_CHARS; n++)
            chars_to_send.push_back(pick_char());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // every character taken and every predicted segment seen
        while (chars_to_send.size() > 0 || chars_if.valid || segs_expected.size() > 0)
            @(posedge clk);
        // stray segments after the last run would still be caught here
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters: %0d letters, %0d digits, %0d spaces, %0d unmapped bytes",
                 chars_taken, letters_sent, digits_sent, spaces_sent, others_sent);
        $display("Checked %0d keying segments, %0d mismatches", segs_seen, mismatches);
        if (mismatches == 0 && segs_expected.size() == 0)
            $display("PASS morse_code_keyer");
        else
            $display("FAIL morse_code_keyer");
        $finish;
    end

endmodule
